### design/pidsr_pkg.sv
// Shared widths, register indexes and stage payload types for the PID step unit.
// Used by every module of the unit and by its checker; depends on nothing.
package pidsr_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int GAIN_WIDTH   = 24;
    localparam int SUM_WIDTH    = 48;
    localparam int FRAC_BITS    = 16;

    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DIFF_W = SAMPLE_WIDTH + 2;
    localparam int MAX_W  = (SUM_WIDTH > DIFF_W) ? SUM_WIDTH : DIFF_W;
    localparam int EXT_W  = MAX_W + 1;

    localparam int PP_PROP_W = GAIN_WIDTH + ERR_W;
    localparam int PP_DER_W  = GAIN_WIDTH + DIFF_W;
    localparam int PP_IH_W   = GAIN_WIDTH + SUM_WIDTH - FRAC_BITS;
    localparam int PP_IL_W   = GAIN_WIDTH + FRAC_BITS + 1;

    localparam int TOT_RAW_W = GAIN_WIDTH + MAX_W - FRAC_BITS + 3;
    localparam int TOT_W     = (TOT_RAW_W > SAMPLE_WIDTH + 2) ? TOT_RAW_W : SAMPLE_WIDTH + 2;

    localparam int IN_DATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * SAMPLE_WIDTH + 1 + 7) / 8) * 8;

    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam int ADDR_W     = REG_IDX_W + 2;
    localparam int REG_COUNT  = 3;

    localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;

    typedef struct packed {
        logic signed [GAIN_WIDTH-1:0] kp;
        logic signed [GAIN_WIDTH-1:0] ki;
        logic signed [GAIN_WIDTH-1:0] kd;
    } t_gains;

    // Loop stage: error, derivative difference and updated sum for one sample.
    typedef struct packed {
        logic signed [ERR_W-1:0]     err;
        logic signed [DIFF_W-1:0]    diff;
        logic signed [SUM_WIDTH-1:0] sum;
        logic                        clip;
    } t_loop;

    // Product stage: the raw partial products, not yet scaled.
    typedef struct packed {
        logic signed [ERR_W-1:0]     err;
        logic signed [PP_PROP_W-1:0] p_prop;
        logic signed [PP_DER_W-1:0]  p_der;
        logic signed [PP_IH_W-1:0]   p_ih;
        logic signed [PP_IL_W-1:0]   p_il;
        logic                        clip;
    } t_prod;

endpackage

### design/pidsr_cfg.sv
// APB register file holding the three loop gains.
// Depends on pidsr_pkg for the register indexes and the gain struct.
module pidsr_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pidsr_pkg::ADDR_W-1:0]      paddr,
    input  logic [pidsr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pidsr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output pidsr_pkg::t_gains                 o_gains
);
    import pidsr_pkg::*;

    t_gains                r_gains;
    logic [REG_IDX_W-1:0]  idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_GAIN_PROP:  r_gains.kp <= pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_INTEG: r_gains.ki <= pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_DERIV: r_gains.kd <= pwdata[GAIN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GAIN_PROP:  prdata = APB_DATA_W'(unsigned'(r_gains.kp));
            REG_GAIN_INTEG: prdata = APB_DATA_W'(unsigned'(r_gains.ki));
            REG_GAIN_DERIV: prdata = APB_DATA_W'(unsigned'(r_gains.kd));
            default:        prdata = '0;
        endcase
    end

    assign o_gains = r_gains;

endmodule

### design/pidsr_loop.sv
// Loop state (previous error, saturating error sum, primed flag) and the
// stage register that carries each sample's error, difference and sum onward.
// Depends on pidsr_pkg for widths and the t_loop payload.
module pidsr_loop (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_clear,
    input  logic                              i_load,
    input  logic signed [pidsr_pkg::ERR_W-1:0] i_err,
    output pidsr_pkg::t_loop                  o_stage
);
    import pidsr_pkg::*;

    localparam logic signed [EXT_W-1:0] SUM_MAX =
        $signed({{(EXT_W - SUM_WIDTH + 1){1'b0}}, {(SUM_WIDTH - 1){1'b1}}});
    localparam logic signed [EXT_W-1:0] SUM_MIN = ~SUM_MAX;

    logic signed [ERR_W-1:0]     r_prev;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic                        r_primed;
    t_loop                       r_stage;

    logic signed [EXT_W-1:0]     ext_sum;
    logic signed [SUM_WIDTH-1:0] n_sum;
    logic                        sum_clip;
    t_loop                       n_stage;

    always_comb begin
        ext_sum  = EXT_W'(r_sum) + EXT_W'(i_err);
        sum_clip = 1'b0;
        if (ext_sum > SUM_MAX) begin
            n_sum    = SUM_MAX[SUM_WIDTH-1:0];
            sum_clip = 1'b1;
        end else if (ext_sum < SUM_MIN) begin
            n_sum    = SUM_MIN[SUM_WIDTH-1:0];
            sum_clip = 1'b1;
        end else begin
            n_sum = ext_sum[SUM_WIDTH-1:0];
        end

        // Before the first sample has been seen, the integral and derivative
        // terms drop out, so their operands go forward as zero.
        n_stage.err = i_err;
        if (r_primed) begin
            n_stage.diff = DIFF_W'(i_err) - DIFF_W'(r_prev);
            n_stage.sum  = n_sum;
            n_stage.clip = sum_clip;
        end else begin
            n_stage.diff = '0;
            n_stage.sum  = '0;
            n_stage.clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_sum    <= '0;
            r_primed <= 1'b0;
        end else if (i_step) begin
            if (i_clear) begin
                r_prev   <= '0;
                r_sum    <= '0;
                r_primed <= 1'b0;
            end else begin
                r_prev   <= i_err;
                r_primed <= 1'b1;
                if (r_primed) begin
                    r_sum <= n_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

### design/pidsr_mult.sv
// Product stage: gain times error, gain times difference, and the integral
// product split into a high and a low partial product around the binary point.
// Depends on pidsr_pkg for widths and the stage payload types.
module pidsr_mult (
    input  logic              i_clk,
    input  logic              i_load,
    input  pidsr_pkg::t_gains i_gains,
    input  pidsr_pkg::t_loop  i_stage,
    output pidsr_pkg::t_prod  o_prod
);
    import pidsr_pkg::*;

    logic signed [SUM_WIDTH-FRAC_BITS-1:0] sum_hi;
    logic signed [FRAC_BITS:0]             sum_lo;
    t_prod                                 n_prod;
    t_prod                                 r_prod;

    assign sum_hi = i_stage.sum[SUM_WIDTH-1:FRAC_BITS];
    assign sum_lo = $signed({1'b0, i_stage.sum[FRAC_BITS-1:0]});

    always_comb begin
        n_prod.err    = i_stage.err;
        n_prod.p_prop = PP_PROP_W'(i_gains.kp) * PP_PROP_W'(i_stage.err);
        n_prod.p_der  = PP_DER_W'(i_gains.kd) * PP_DER_W'(i_stage.diff);
        n_prod.p_ih   = PP_IH_W'(i_gains.ki) * PP_IH_W'(sum_hi);
        n_prod.p_il   = PP_IL_W'(i_gains.ki) * PP_IL_W'(sum_lo);
        n_prod.clip   = i_stage.clip;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

### design/pidsr_out.sv
// Term sum with the half offset, then the halving, drive saturation and result register.
// Depends on pidsr_pkg for widths and the product payload.
module pidsr_out (
    input  logic                                      i_clk,
    input  logic                                      i_load_sum,
    input  logic                                      i_load_out,
    input  pidsr_pkg::t_prod                          i_prod,
    output logic signed [pidsr_pkg::SAMPLE_WIDTH-1:0] o_drive,
    output logic signed [pidsr_pkg::ERR_W-1:0]        o_err,
    output logic                                      o_clip
);
    import pidsr_pkg::*;

    localparam logic signed [TOT_W-1:0] Q_ONE = TOT_W'(1) <<< FRAC_BITS;
    localparam logic signed [TOT_W-1:0] DRV_MAX =
        $signed({{(TOT_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}});
    localparam logic signed [TOT_W-1:0] DRV_MIN = ~DRV_MAX;

    logic signed [PP_PROP_W-FRAC_BITS-1:0] t_prop;
    logic signed [PP_DER_W-FRAC_BITS-1:0]  t_der;
    logic signed [PP_IL_W-FRAC_BITS-1:0]   t_il;
    logic signed [TOT_W-1:0]               n_total;

    logic signed [TOT_W-1:0]        r_total;
    logic signed [ERR_W-1:0]        r_err4;
    logic                           r_clip4;

    logic signed [TOT_W-1:0]        half;
    logic signed [SAMPLE_WIDTH-1:0] n_drive;
    logic                           drv_clip;

    logic signed [SAMPLE_WIDTH-1:0] r_drive;
    logic signed [ERR_W-1:0]        r_err5;
    logic                           r_clip5;

    // Arithmetic shifts give the floor of each product over 2^16; the
    // integral low part only contributes its floored fraction carry.
    assign t_prop  = i_prod.p_prop[PP_PROP_W-1:FRAC_BITS];
    assign t_der   = i_prod.p_der[PP_DER_W-1:FRAC_BITS];
    assign t_il    = i_prod.p_il[PP_IL_W-1:FRAC_BITS];
    assign n_total = TOT_W'(t_prop) + TOT_W'(t_der) + TOT_W'(i_prod.p_ih)
                   + TOT_W'(t_il) + Q_ONE;

    always_ff @(posedge i_clk) begin
        if (i_load_sum) begin
            r_total <= n_total;
            r_err4  <= i_prod.err;
            r_clip4 <= i_prod.clip;
        end
    end

    always_comb begin
        half     = r_total >>> 1;
        drv_clip = 1'b0;
        if (half > DRV_MAX) begin
            n_drive  = DRV_MAX[SAMPLE_WIDTH-1:0];
            drv_clip = 1'b1;
        end else if (half < DRV_MIN) begin
            n_drive  = DRV_MIN[SAMPLE_WIDTH-1:0];
            drv_clip = 1'b1;
        end else begin
            n_drive = half[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_drive <= n_drive;
            r_err5  <= r_err4;
            r_clip5 <= r_clip4 | drv_clip;
        end
    end

    assign o_drive = r_drive;
    assign o_err   = r_err5;
    assign o_clip  = r_clip5;

endmodule

### design/pid_step_rescaled_unit.sv
// Path: a run request accepted at the input goes through the input, loop, product, sum and result
// stage registers in that order; a stall on the output side holds it on the way.
// Throughput: one request per cycle while the output side does not stall.
// A clear request takes one input slot and gives no result.
// Reset is synchronous and active low: it empties the pipeline and zeroes loop state and gains.
module pid_step_rescaled_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: setpoint [31:0], measured [63:32]
    input  logic [pidsr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: mode (0 = run step, 1 = clear loop state)
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: drive [31:0], error_value [64:32], zero fill above
    output logic [pidsr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tuser: saturated
    output logic                                 m_axis_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pidsr_pkg::ADDR_W-1:0]         paddr,
    input  logic [pidsr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pidsr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import pidsr_pkg::*;

    t_gains gains;
    t_loop  loop_stage;
    t_prod  prod_stage;

    logic signed [SAMPLE_WIDTH-1:0] in_sp;
    logic signed [SAMPLE_WIDTH-1:0] in_ms;

    logic                    r_v1, r_v2, r_v3, r_v4, r_v5;
    logic                    r_mode1;
    logic signed [ERR_W-1:0] r_err1;

    logic adv1, adv2, adv3, adv4, adv5;

    logic signed [SAMPLE_WIDTH-1:0] out_drive;
    logic signed [ERR_W-1:0]        out_err;
    logic                           out_clip;

    // A stage may load when it is empty or its content moves on this cycle,
    // so bubbles close up even while the result register is stalled.
    assign adv5 = !r_v5 || m_axis_tready;
    assign adv4 = !r_v4 || adv5;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign s_axis_tready = adv1;

    assign in_sp = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign in_ms = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= s_axis_tvalid;
            if (adv2) r_v2 <= r_v1 && !r_mode1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
            if (adv5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_mode1 <= s_axis_tuser;
            r_err1  <= ERR_W'(in_ms) - ERR_W'(in_sp);
        end
    end

    pidsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (gains)
    );

    pidsr_loop u_loop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv2 && r_v1),
        .i_clear (r_mode1),
        .i_load  (adv2),
        .i_err   (r_err1),
        .o_stage (loop_stage)
    );

    pidsr_mult u_mult (
        .i_clk   (i_clk),
        .i_load  (adv3),
        .i_gains (gains),
        .i_stage (loop_stage),
        .o_prod  (prod_stage)
    );

    pidsr_out u_out (
        .i_clk      (i_clk),
        .i_load_sum (adv4),
        .i_load_out (adv5),
        .i_prod     (prod_stage),
        .o_drive    (out_drive),
        .o_err      (out_err),
        .o_clip     (out_clip)
    );

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = OUT_DATA_W'({out_err, out_drive});
    assign m_axis_tuser  = out_clip;

endmodule

### design/pidsr_checker.sv
// Port-level checker for the PID step unit, attached to the top level by bind.
// Depends on pidsr_pkg for field positions and widths.
module pidsr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic [pidsr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input logic                                 s_axis_tuser,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [pidsr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic                                 m_axis_tuser,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [pidsr_pkg::ADDR_W-1:0]         paddr,
    input logic [pidsr_pkg::APB_DATA_W-1:0]     pwdata,
    input logic [pidsr_pkg::APB_DATA_W-1:0]     prdata,
    input logic                                 pready
);
    import pidsr_pkg::*;

    logic [ERR_W-1:0] in_err;

    assign in_err = {s_axis_tdata[2*SAMPLE_WIDTH-1], s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]}
                  - {s_axis_tdata[SAMPLE_WIDTH-1], s_axis_tdata[SAMPLE_WIDTH-1:0]};

    // No result may be offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // With the output always ready, a run request shows up as a result
    // carrying measured minus setpoint.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) ##1 m_axis_tready
            ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid && m_axis_tdata[2*SAMPLE_WIDTH:SAMPLE_WIDTH] == $past(in_err, 5))
        else $error("run request result missing or wrong error value");

    // A gain written and then read back at once returns the written bits.
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] < REG_COUNT)
            ##1 (psel && !pwrite && paddr == $past(paddr))
        |-> prdata[GAIN_WIDTH-1:0] == $past(pwdata[GAIN_WIDTH-1:0]))
        else $error("gain readback mismatch");

endmodule

bind pid_step_rescaled_unit pidsr_checker u_pidsr_checker (.*);
